// ===== src/flvs_pkg.sv =====
// Shared types and constants for the field load variance statistics block.
package flvs_pkg;

    localparam int MAX_CELLS = 1024;
    localparam int CNT_W     = $clog2(MAX_CELLS + 1);
    localparam int SAMPLE_W  = 24;
    localparam int SUM_W     = SAMPLE_W + CNT_W - 1;
    localparam int SQ_W      = 2 * SAMPLE_W + CNT_W - 1;
    localparam int CAP_W     = 32;
    localparam int METRIC_W  = 17;
    localparam int STEP_W    = 32;

    // Shared restoring divider widths.
    localparam int DIV_W  = 64;
    localparam int DIVS_W = 65;
    localparam int QCNT_W = 7;

    localparam logic [METRIC_W-1:0] ONE_Q16     = METRIC_W'(65536);
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX  = '1;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                last;
    } in_item_t;

    typedef struct packed {
        logic [METRIC_W-1:0] stability;
        logic [METRIC_W-1:0] coherence;
        logic [SAMPLE_W-1:0] divergence;
        logic [STEP_W-1:0]   step_number;
    } out_item_t;

    // Which quotient the datapath is computing.
    typedef enum logic [2:0] {
        OP_MEAN,
        OP_MEANSQ,
        OP_STAB,
        OP_DVG,
        OP_COH
    } op_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic accum;
        logic div_start;
        op_t  op;
        logic sq_load;
        logic clear;
    } cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic div_done;
        logic stab_zero;   // zero capacity or sum at or above capacity
        logic one_cell;    // vector holds at most one counted cell
    } status_t;

endpackage

// ===== src/field_load_variance_stats.sv =====
// Top level of the field load variance statistics block.
//
// Usage: samples arrive on in_valid/in_stall with in_item (sample, last).
// While a vector accumulates, one request is taken each cycle. On the request
// flagged last the block stalls its input and runs up to five divisions on
// one shared 64-step restoring divider (mean, mean square, coherence,
// stability, divergence; the last two may be skipped), then shows one result
// on out_valid/out_item. The result holds until out_stall is low; the
// accumulators then clear and input resumes the next cycle.
// Within a vector one sample is taken per cycle; from the last request until
// the result is taken the input stalls, so a new vector waits for the divider.
// Capacity is written over cfg_valid/cfg_ready/cfg_data, taken at any time;
// it is used only by the stability division.
// Reset clears capacity, the accumulators and the step counter; no result is
// pending after reset.
module field_load_variance_stats (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  flvs_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_stall,
    output flvs_pkg::out_item_t out_item,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [flvs_pkg::CAP_W-1:0] cfg_data
);
    logic [flvs_pkg::CAP_W-1:0]    capacity_reg;
    flvs_pkg::cmd_t                cmd;
    flvs_pkg::status_t             status;
    logic [flvs_pkg::METRIC_W-1:0] stab;
    logic [flvs_pkg::METRIC_W-1:0] coh;
    logic [flvs_pkg::SAMPLE_W-1:0] dvg;
    logic [flvs_pkg::STEP_W-1:0]   step;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            capacity_reg <= '0;
        else if (cfg_valid && cfg_ready)
            capacity_reg <= cfg_data;
    end

    flvs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_last   (in_item.last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd),
        .step_reg  (step)
    );

    flvs_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .capacity (capacity_reg),
        .in_item  (in_item),
        .cmd      (cmd),
        .status   (status),
        .stab_out (stab),
        .coh_out  (coh),
        .dvg_out  (dvg)
    );

    assign out_item.stability   = stab;
    assign out_item.coherence   = coh;
    assign out_item.divergence  = dvg;
    assign out_item.step_number = step;

endmodule

// ===== src/flvs_datapath.sv =====
// Accumulators, shared serial divider and metric registers.
module flvs_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [flvs_pkg::CAP_W-1:0] capacity,
    input  flvs_pkg::in_item_t in_item,
    input  flvs_pkg::cmd_t     cmd,
    output flvs_pkg::status_t  status,
    output logic [flvs_pkg::METRIC_W-1:0] stab_out,
    output logic [flvs_pkg::METRIC_W-1:0] coh_out,
    output logic [flvs_pkg::SAMPLE_W-1:0] dvg_out
);
    localparam int DW = flvs_pkg::DIV_W;

    logic [flvs_pkg::SUM_W-1:0]    sum_reg;
    logic [flvs_pkg::SQ_W-1:0]     sq_reg;
    logic [flvs_pkg::SUM_W-1:0]    dsum_reg;
    logic [flvs_pkg::SAMPLE_W-1:0] prev_reg;
    logic [flvs_pkg::CNT_W-1:0]    cnt_reg;
    logic [2*flvs_pkg::SAMPLE_W-1:0] sqr_reg;
    logic                          sqv_reg;

    logic [DW-1:0]              num_reg;
    logic [DW-1:0]              den_reg;
    logic [DW-1:0]              quo_reg;
    logic [flvs_pkg::DIVS_W-1:0] rem_reg;
    logic [flvs_pkg::QCNT_W-1:0] it_reg;
    logic                       busy_reg;
    logic                       done_reg;

    logic [flvs_pkg::SAMPLE_W-1:0] mean_reg;
    logic [DW-1:0]                 msq_reg;
    logic [47:0]                   mm_reg;

    logic [flvs_pkg::SAMPLE_W-1:0] diff;
    logic [flvs_pkg::DIVS_W-1:0]   rem_sh;
    logic [flvs_pkg::DIVS_W-1:0]   rem_sub;
    logic [DW-1:0]                 var_val;
    logic [DW-1:0]                 op_num;
    logic [DW-1:0]                 op_den;

    assign diff = (in_item.sample >= prev_reg) ? in_item.sample - prev_reg
                                               : prev_reg - in_item.sample;
    assign var_val = (msq_reg > DW'(mm_reg)) ? msq_reg - DW'(mm_reg) : '0;

    // Operand selection for the next division.
    always_comb
    begin
        op_num = '0;
        op_den = DW'(1);
        unique case (cmd.op)
            flvs_pkg::OP_MEAN:
            begin
                op_num = DW'(sum_reg);
                op_den = DW'(cnt_reg);
            end
            flvs_pkg::OP_MEANSQ:
            begin
                op_num = DW'(sq_reg);
                op_den = DW'(cnt_reg);
            end
            flvs_pkg::OP_STAB:
            begin
                op_num = DW'(DW'(capacity) - DW'(sum_reg)) << 16;
                op_den = DW'(capacity);
            end
            flvs_pkg::OP_DVG:
            begin
                op_num = DW'(dsum_reg);
                op_den = DW'(cnt_reg - flvs_pkg::CNT_W'(1));
            end
            flvs_pkg::OP_COH:
            begin
                op_num = DW'(1) << 48;
                op_den = (DW'(1) << 32) + var_val;
            end
            default:
            begin
                op_num = '0;
                op_den = DW'(1);
            end
        endcase
    end

    assign rem_sh  = {rem_reg[flvs_pkg::DIVS_W-2:0], num_reg[DW-1]};
    assign rem_sub = rem_sh - {1'b0, den_reg};

    // Status back to the controller; skip decisions for stability and divergence.
    assign status.div_done  = done_reg;
    assign status.stab_zero = (capacity == '0) ||
                              (sum_reg >= flvs_pkg::SUM_W'(capacity));
    assign status.one_cell  = (cnt_reg <= flvs_pkg::CNT_W'(1));

    // Accumulators and squaring register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            sq_reg   <= '0;
            dsum_reg <= '0;
            prev_reg <= '0;
            cnt_reg  <= '0;
            sqv_reg  <= 1'b0;
        end
        else if (cmd.clear)
        begin
            sum_reg  <= '0;
            sq_reg   <= '0;
            dsum_reg <= '0;
            prev_reg <= '0;
            cnt_reg  <= '0;
            sqv_reg  <= 1'b0;
        end
        else
        begin
            sqv_reg <= 1'b0;
            if (sqv_reg)
                sq_reg <= sq_reg + flvs_pkg::SQ_W'(sqr_reg);
            if (cmd.accum && cnt_reg < flvs_pkg::CNT_W'(flvs_pkg::MAX_CELLS))
            begin
                if (cnt_reg != '0)
                    dsum_reg <= dsum_reg + flvs_pkg::SUM_W'(diff);
                sum_reg  <= sum_reg + flvs_pkg::SUM_W'(in_item.sample);
                prev_reg <= in_item.sample;
                cnt_reg  <= cnt_reg + flvs_pkg::CNT_W'(1);
                sqv_reg  <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sqr_reg <= in_item.sample * in_item.sample;
        if (cmd.sq_load)
            mm_reg <= mean_reg * mean_reg;
    end

    // Restoring divider, one quotient bit per cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            it_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.div_start)
            begin
                busy_reg <= 1'b1;
                it_reg   <= '0;
            end
            else if (busy_reg)
            begin
                it_reg <= it_reg + flvs_pkg::QCNT_W'(1);
                if (it_reg == flvs_pkg::QCNT_W'(DW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            num_reg <= op_num;
            den_reg <= op_den;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[DW-2:0], 1'b0};
            if (!rem_sub[flvs_pkg::DIVS_W-1])
            begin
                rem_reg <= rem_sub;
                quo_reg <= {quo_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_reg[DW-2:0], 1'b0};
            end
        end
    end

    // Capture each quotient into its metric register; skipped metrics stay zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mean_reg <= '0;
            msq_reg  <= '0;
            stab_out <= '0;
            coh_out  <= '0;
            dvg_out  <= '0;
        end
        else if (cmd.clear)
        begin
            stab_out <= '0;
            dvg_out  <= '0;
        end
        else if (done_reg)
        begin
            unique case (cmd.op)
                flvs_pkg::OP_MEAN:   mean_reg <= quo_reg[flvs_pkg::SAMPLE_W-1:0];
                flvs_pkg::OP_MEANSQ: msq_reg  <= quo_reg;
                flvs_pkg::OP_STAB:
                    stab_out <= (quo_reg > DW'(flvs_pkg::ONE_Q16)) ? flvs_pkg::ONE_Q16
                                : quo_reg[flvs_pkg::METRIC_W-1:0];
                flvs_pkg::OP_DVG:
                    dvg_out <= (quo_reg > DW'(flvs_pkg::SAMPLE_MAX)) ? flvs_pkg::SAMPLE_MAX
                               : quo_reg[flvs_pkg::SAMPLE_W-1:0];
                flvs_pkg::OP_COH:
                    coh_out <= (quo_reg > DW'(flvs_pkg::ONE_Q16)) ? flvs_pkg::ONE_Q16
                               : quo_reg[flvs_pkg::METRIC_W-1:0];
                default: ;
            endcase
        end
    end

    property p_cnt_bound;
        @(posedge clk) disable iff (!rst_n)
        cnt_reg <= flvs_pkg::CNT_W'(flvs_pkg::MAX_CELLS);
    endproperty
    a_cnt_bound: assert property (p_cnt_bound) else $error("sample count overflow");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg) else $error("divider done held");

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !busy_reg) else $error("divider restarted while busy");

endmodule

// ===== src/flvs_ctrl.sv =====
// Controller sequencing accumulation and the per-vector divisions.
module flvs_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               in_last,
    output logic               out_valid,
    input  logic               out_stall,
    input  flvs_pkg::status_t  status,
    output flvs_pkg::cmd_t     cmd,
    output logic [flvs_pkg::STEP_W-1:0] step_reg
);
    typedef enum logic [3:0] {
        S_ACC, S_SQWAIT, S_MEAN, S_MEANSQ, S_MM, S_COH, S_STAB, S_DVG,
        S_CLEAR, S_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   started_reg;
    logic   started_next;
    logic   accept;

    assign in_stall = (state_reg != S_ACC);
    assign accept   = in_valid && !in_stall;
    assign out_valid = (state_reg == S_OUT);

    // Next state and command decode.
    always_comb
    begin
        state_next   = state_reg;
        started_next = started_reg;
        cmd          = '0;
        cmd.op       = flvs_pkg::OP_MEAN;
        unique case (state_reg)
            S_ACC:
            begin
                cmd.accum = in_valid;
                if (accept && in_last)
                    state_next = S_SQWAIT;
            end
            S_SQWAIT:
            begin
                cmd.op = flvs_pkg::OP_MEAN;
                cmd.div_start = 1'b1;
                state_next = S_MEAN;
            end
            S_MEAN:
            begin
                cmd.op = flvs_pkg::OP_MEAN;
                if (status.div_done)
                begin
                    cmd.op = flvs_pkg::OP_MEAN;
                    state_next = S_MEANSQ;
                    started_next = 1'b0;
                end
            end
            S_MEANSQ:
            begin
                cmd.op = flvs_pkg::OP_MEANSQ;
                if (!started_reg)
                begin
                    cmd.div_start = 1'b1;
                    started_next = 1'b1;
                end
                else if (status.div_done)
                    state_next = S_MM;
            end
            S_MM:
            begin
                cmd.op = flvs_pkg::OP_COH;
                cmd.sq_load = 1'b1;
                state_next = S_COH;
                started_next = 1'b0;
            end
            S_COH:
            begin
                cmd.op = flvs_pkg::OP_COH;
                if (!started_reg)
                begin
                    cmd.div_start = 1'b1;
                    started_next = 1'b1;
                end
                else if (status.div_done)
                begin
                    state_next = S_STAB;
                    started_next = 1'b0;
                end
            end
            S_STAB:
            begin
                cmd.op = flvs_pkg::OP_STAB;
                if (!started_reg)
                begin
                    if (status.stab_zero)
                    begin
                        state_next = S_DVG;
                        started_next = 1'b0;
                    end
                    else
                    begin
                        cmd.div_start = 1'b1;
                        started_next = 1'b1;
                    end
                end
                else if (status.div_done)
                begin
                    state_next = S_DVG;
                    started_next = 1'b0;
                end
            end
            S_DVG:
            begin
                cmd.op = flvs_pkg::OP_DVG;
                if (!started_reg)
                begin
                    if (status.one_cell)
                        state_next = S_CLEAR;
                    else
                    begin
                        cmd.div_start = 1'b1;
                        started_next = 1'b1;
                    end
                end
                else if (status.div_done)
                    state_next = S_CLEAR;
            end
            S_CLEAR:
            begin
                cmd.op = flvs_pkg::OP_DVG;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                cmd.op = flvs_pkg::OP_DVG;
                if (!out_stall)
                begin
                    cmd.clear = 1'b1;
                    state_next = S_ACC;
                end
            end
            default: state_next = S_ACC;
        endcase
    end

    // State and step counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_ACC;
            started_reg <= 1'b0;
            step_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            started_reg <= started_next;
            if (state_reg == S_CLEAR)
                step_reg <= step_reg + flvs_pkg::STEP_W'(1);
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid) else $error("result dropped");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall) else $error("input taken during result");
    a_start_once: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> !cmd.div_start) else $error("double divider start");

endmodule
